// ----- hw/rtl/scst_pkg.sv -----
// Shared types and constants for the shadow call stack tracker.
// Used by every module under hw/rtl; depends on nothing else.
package scst_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned DEPTH_W         = 7;

  // Input transfer layout on tdata, lowest bits first.
  localparam int unsigned IN_DATA_W  = 4 * ADDR_W;
  // Result layout on tdata: depth, tail_call, overflow, underflow, zero fill.
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_TAIL   = DEPTH_W;
  localparam int unsigned OUT_OVF    = DEPTH_W + 1;
  localparam int unsigned OUT_UNF    = DEPTH_W + 2;
  localparam int unsigned OUT_USED_W = DEPTH_W + 3;

  // Event kinds carried on tuser.
  localparam logic EV_CALL = 1'b0;
  localparam logic EV_RET  = 1'b1;

  typedef struct packed {
    logic              tail;
    logic [ADDR_W-1:0] sp;
    logic [ADDR_W-1:0] ret;
    logic [ADDR_W-1:0] tgt;
  } frame_t;

  typedef struct packed {
    logic              is_ret;
    logic [ADDR_W-1:0] caller;
    logic [ADDR_W-1:0] sp;
    logic [ADDR_W-1:0] ret;
    logic [ADDR_W-1:0] tgt;
  } event_t;

  // Outcome of comparing the pending event against the top frame.
  typedef struct packed {
    logic sp_lt;
    logic sp_eq;
    logic tgt_eq;
    logic ret_eq;
  } cmp_t;

endpackage

// ----- hw/rtl/scst_frame_mem.sv -----
// Frame storage of the shadow call stack: one write port, one registered read port.
// Depends on scst_pkg for the frame type.
module scst_frame_mem #(
  parameter int unsigned STACK_DEPTH = scst_pkg::STACK_DEPTH_DEF,
  parameter int unsigned AW          = $clog2(STACK_DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  scst_pkg::frame_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output scst_pkg::frame_t rdata_o
);

  scst_pkg::frame_t mem_q [STACK_DEPTH];
  scst_pkg::frame_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/scst_cmp.sv -----
// Compare unit for calls and return search: checks the pending event against the top frame.
// Depends on scst_pkg for the event, frame and result types.
module scst_cmp (
  input  scst_pkg::event_t ev_i,
  input  scst_pkg::frame_t frame_i,
  output scst_pkg::cmp_t   cmp_o
);

  always_comb begin
    cmp_o.sp_lt  = ev_i.sp < frame_i.sp;
    cmp_o.sp_eq  = ev_i.sp == frame_i.sp;
    cmp_o.tgt_eq = ev_i.caller == frame_i.tgt;
    cmp_o.ret_eq = ev_i.ret == frame_i.ret;
  end

endmodule

// ----- hw/rtl/shadow_call_stack_tracker_core.sv -----
// Shadow call stack tracker. Each input transfer is a call or a return event; each produces
// exactly one result transfer with the new depth and the tail-call, overflow and underflow
// flags. A small sequencer walks the stack one frame a cycle, and a single compare unit checks
// the top frame read from the registered frame memory. A call pops its frames and then spends
// a further step pushing or refusing the new frame before the output state. A return that
// finds its frame leaves for the output state with its last pop; one that runs the stack empty
// spends a further step on the empty check. A stalled result holds the sequencer in its output
// state. The input is ready again in the cycle after the result is loaded, and not while an
// event is being worked on. No clearing pass follows reset.
// Depends on scst_pkg, scst_cmp and scst_frame_mem.
module shadow_call_stack_tracker_core #(
  parameter int unsigned STACK_DEPTH = scst_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: target_entry, return_addr, stack_ptr, caller_entry
  input  logic [scst_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: func (0 = call, 1 = return)
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: depth[6:0], tail_call, overflow, underflow, zero fill
  output logic [scst_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CALL  = 5'b00010,
    S_RFIND = 5'b00100,
    S_RTAIL = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  scst_pkg::event_t ev_q, ev_d;
  logic tail_q, tail_d, ovf_q, ovf_d, unf_q, unf_d;
  logic out_valid_q;
  logic [scst_pkg::OUT_DATA_W-1:0] out_data_q;

  logic             we;
  logic [AW-1:0]    raddr;
  scst_pkg::frame_t wframe, top;
  scst_pkg::cmp_t   cmp;
  logic             empty, out_free;

  scst_cmp u_cmp (
    .ev_i    (ev_q),
    .frame_i (top),
    .cmp_o   (cmp)
  );

  scst_frame_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (wframe),
    .raddr_i (raddr),
    .rdata_o (top)
  );

  assign empty    = cnt_q == '0;
  assign out_free = !out_valid_q || m_axis_tready;

  // The read port fetches next cycle's top frame; on a push it returns that slot's old contents.
  assign raddr = AW'(cnt_d - CW'(1));

  assign wframe.tgt  = ev_q.tgt;
  assign wframe.ret  = ev_q.ret;
  assign wframe.sp   = ev_q.sp;
  assign wframe.tail = tail_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ev_d    = ev_q;
    tail_d  = tail_q;
    ovf_d   = ovf_q;
    unf_d   = unf_q;
    we      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          ev_d.tgt    = s_axis_tdata[scst_pkg::ADDR_W-1:0];
          ev_d.ret    = s_axis_tdata[2*scst_pkg::ADDR_W-1:scst_pkg::ADDR_W];
          ev_d.sp     = s_axis_tdata[3*scst_pkg::ADDR_W-1:2*scst_pkg::ADDR_W];
          ev_d.caller = s_axis_tdata[4*scst_pkg::ADDR_W-1:3*scst_pkg::ADDR_W];
          ev_d.is_ret = s_axis_tuser;
          tail_d      = 1'b0;
          ovf_d       = 1'b0;
          unf_d       = 1'b0;
          state_d     = (s_axis_tuser == scst_pkg::EV_RET) ? S_RFIND : S_CALL;
        end
      end
      S_CALL: begin
        if (!empty && !cmp.sp_lt && !(cmp.sp_eq && cmp.tgt_eq)) begin
          cnt_d = cnt_q - CW'(1);
        end else if (cnt_q >= FULL) begin
          ovf_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          tail_d  = !empty && cmp.sp_eq && cmp.ret_eq;
          we      = 1'b1;
          cnt_d   = cnt_q + CW'(1);
          state_d = S_OUT;
        end
      end
      S_RFIND: begin
        if (empty) begin
          unf_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q - CW'(1);
          // A matching frame that is itself tail-marked starts the tail sweep.
          if (cmp.sp_eq) begin
            state_d = top.tail ? S_RTAIL : S_OUT;
          end
        end
      end
      S_RTAIL: begin
        if (empty) begin
          unf_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q - CW'(1);
          if (!top.tail) begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    tail_q <= tail_d;
    ovf_q  <= ovf_d;
    unf_q  <= unf_d;
    if (state_q == S_OUT && out_free) begin
      out_data_q <= {(scst_pkg::OUT_DATA_W - scst_pkg::OUT_USED_W)'(0),
                     unf_q, ovf_q, tail_q, scst_pkg::DEPTH_W'(cnt_q)};
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- hw/rtl/scst_checker.sv -----
// Port-level checks for the shadow call stack tracker, bound to the top level.
// Depends on scst_pkg for the result layout and on shadow_call_stack_tracker_core.
module scst_checker #(
  parameter int unsigned STACK_DEPTH = scst_pkg::STACK_DEPTH_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [scst_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic [scst_pkg::DEPTH_W-1:0] depth;
  logic tail, ovf, unf;

  assign depth = m_axis_tdata[scst_pkg::DEPTH_W-1:0];
  assign tail  = m_axis_tdata[scst_pkg::OUT_TAIL];
  assign ovf   = m_axis_tdata[scst_pkg::OUT_OVF];
  assign unf   = m_axis_tdata[scst_pkg::OUT_UNF];

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // At most one result flag is set on any result.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $countones({tail, ovf, unf}) <= 1)
    else $error("more than one result flag set");

  // A refused push leaves the stack full.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ovf |-> depth == scst_pkg::DEPTH_W'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

  // Underflow always ends on an empty stack.
  a_unf_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && unf |-> depth == '0)
    else $error("underflow reported with frames left");

  // An accepted event keeps the input not ready while it is worked on and in the output state.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input ready too soon after a transfer");

endmodule

bind shadow_call_stack_tracker_core scst_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_scst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- test/tb_shadow_call_stack_tracker_core.sv -----
// Testbench for shadow_call_stack_tracker_core: call and return events go in over the input
// stream, and each result is checked against a shadow stack kept inside the testbench.
// Depends on scst_pkg and the tracker RTL only.
module tb_shadow_call_stack_tracker_core;
  import scst_pkg::*;

  localparam int unsigned STACK_DEPTH = STACK_DEPTH_DEF;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               tail;
    logic               ovf;
    logic               unf;
  } stack_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow copy of the frame stack, updated once per accepted event.
  logic [ADDR_W-1:0] shadow_tgt [STACK_DEPTH];
  logic [ADDR_W-1:0] shadow_ret [STACK_DEPTH];
  logic [ADDR_W-1:0] shadow_sp  [STACK_DEPTH];
  logic              shadow_tail[STACK_DEPTH];
  int unsigned       shadow_count;

  stack_result_t pending_results[$];
  stack_result_t want;
  int unsigned   errors;
  int unsigned   hold_len;
  bit            idle_on;

  shadow_call_stack_tracker_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic stack_result_t predict_event(event_t ev);
    stack_result_t r;
    int unsigned   top;
    bit            stop;
    r = '0;
    if (ev.is_ret == EV_CALL) begin
      stop = 1'b0;
      while (shadow_count > 0 && !stop) begin
        top = shadow_count - 1;
        if (ev.sp < shadow_sp[top]) stop = 1'b1;
        else if (ev.sp == shadow_sp[top] && ev.caller == shadow_tgt[top]) stop = 1'b1;
        else shadow_count--;
      end
      if (shadow_count >= STACK_DEPTH) begin
        r.ovf = 1'b1;
      end else begin
        if (shadow_count > 0) begin
          top = shadow_count - 1;
          r.tail = (ev.sp == shadow_sp[top]) && (ev.ret == shadow_ret[top]);
        end
        shadow_tgt[shadow_count]  = ev.tgt;
        shadow_ret[shadow_count]  = ev.ret;
        shadow_sp[shadow_count]   = ev.sp;
        shadow_tail[shadow_count] = r.tail;
        shadow_count++;
      end
    end else begin
      while (shadow_count > 0 && shadow_sp[shadow_count-1] != ev.sp) shadow_count--;
      if (shadow_count == 0) begin
        r.unf = 1'b1;
      end else begin
        while (shadow_count > 0 && shadow_tail[shadow_count-1]) shadow_count--;
        if (shadow_count == 0) r.unf = 1'b1;
        else shadow_count--;
      end
    end
    r.depth = shadow_count[DEPTH_W-1:0];
    return r;
  endfunction

  function automatic event_t mk_event(logic is_ret, logic [ADDR_W-1:0] tgt,
                                      logic [ADDR_W-1:0] ret, logic [ADDR_W-1:0] sp,
                                      logic [ADDR_W-1:0] caller);
    event_t ev;
    ev.is_ret = is_ret;
    ev.tgt    = tgt;
    ev.ret    = ret;
    ev.sp     = sp;
    ev.caller = caller;
    return ev;
  endfunction

  // Mostly plausible call/return traffic built from the current shadow stack, with some noise.
  function automatic event_t next_event(int unsigned push_pct);
    event_t      ev;
    int unsigned top;
    int unsigned pick;
    int unsigned roll;
    ev = mk_event(EV_CALL, $urandom, $urandom, $urandom, $urandom);
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      ev.is_ret = 1'($urandom_range(0, 1));
    end else if (shadow_count != 0) begin
      top  = shadow_count - 1;
      pick = ($urandom_range(0, 1) == 0) ? top : $urandom_range(0, top);
      if ($urandom_range(0, 99) < push_pct) begin
        case ($urandom_range(0, 9))
          0: begin
            ev.sp     = shadow_sp[top];
            ev.ret    = shadow_ret[top];
            ev.caller = shadow_tgt[top];
          end
          1: begin
            ev.sp  = shadow_sp[top];
            ev.ret = shadow_ret[top];
          end
          2: begin
            ev.sp     = shadow_sp[top];
            ev.caller = shadow_tgt[top];
          end
          3: begin
            ev.sp     = shadow_sp[pick];
            ev.caller = shadow_tgt[pick];
          end
          4: ev.sp = shadow_sp[pick] + $urandom_range(0, 3);
          default: begin
            ev.sp     = shadow_sp[top] - $urandom_range(1, 256);
            ev.caller = shadow_tgt[top];
          end
        endcase
      end else begin
        ev.is_ret = EV_RET;
        if ($urandom_range(0, 19) != 0) ev.sp = shadow_sp[pick];
      end
    end
    return ev;
  endfunction

  task automatic send_event(input event_t ev);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ev.caller, ev.sp, ev.ret, ev.tgt};
    s_axis_tuser  <= ev.is_ret;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.insert(pending_results.size(), predict_event(ev));
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_event(mk_event(EV_RET, '1, '1, '1, '1));
    send_event(mk_event(EV_CALL, '0, '0, '0, '0));
    // Same pointer, same return address and caller is the top's target: tail call kept on top.
    send_event(mk_event(EV_CALL, 32'h1, '0, '0, '0));
    send_event(mk_event(EV_RET, '0, '0, '0, '0));
    send_event(mk_event(EV_CALL, '1, '1, '1, '1));
    send_event(mk_event(EV_CALL, 32'h0000_1000, 32'h1234_5678, 32'hFFFF_FF00, '1));
    // Equal pointer but a different caller replaces the top frame.
    send_event(mk_event(EV_CALL, 32'h0000_2000, 32'h1234_5678, 32'hFFFF_FF00, 32'h5));
    send_event(mk_event(EV_CALL, 32'h0000_3000, 32'hAAAA_5555, 32'hFFFF_FF00, 32'h0000_2000));
    send_event(mk_event(EV_CALL, 32'h0000_4000, 32'h5555_AAAA, 32'hFFFF_FE00, 32'h0000_3000));
    send_event(mk_event(EV_CALL, 32'h0000_5000, 32'h0BAD_F00D, 32'hFFFF_FFFF, 32'h0));
    send_event(mk_event(EV_RET, 32'hDEAD_BEEF, 32'h0, 32'h5, 32'h0));
    send_event(mk_event(EV_RET, 32'h0, 32'h0, 32'h5, 32'h0));
    send_event(mk_event(EV_CALL, 32'h0000_0100, 32'h0000_0010, 32'h0000_1000, 32'h0));
    send_event(mk_event(EV_CALL, 32'h0000_0200, 32'h0000_0020, 32'h0000_0F00, 32'h0000_0100));
    send_event(mk_event(EV_CALL, 32'h0000_0300, 32'h0000_0020, 32'h0000_0F00, 32'h0000_0200));
    send_event(mk_event(EV_CALL, 32'h0000_0400, 32'h0000_0020, 32'h0000_0F00, 32'h0000_0300));
    // Return pops both tail-marked frames and then the frame they replaced.
    send_event(mk_event(EV_RET, 32'h7777_7777, 32'h0000_0020, 32'h0000_0F00, 32'h0));
    send_event(mk_event(EV_RET, 32'h0, 32'h0000_0010, 32'h0000_1000, 32'h0));
    wait_results_drained();
  endtask

  task automatic test_full_stack();
    logic [ADDR_W-1:0] sp;
    while (shadow_count != 0) send_event(mk_event(EV_RET, $urandom, $urandom, shadow_sp[0], 0));
    while (shadow_count < STACK_DEPTH) begin
      sp = (shadow_count == 0) ? 32'hFFFF_F000 : shadow_sp[shadow_count-1] - 32'd16;
      send_event(mk_event(EV_CALL, $urandom, $urandom, sp, $urandom));
    end
    send_event(mk_event(EV_CALL, $urandom, $urandom, sp - 32'd16, $urandom));
    // The tail condition holds here, but a refused push reports no tail call.
    send_event(mk_event(EV_CALL, $urandom, shadow_ret[STACK_DEPTH-1], sp,
                        shadow_tgt[STACK_DEPTH-1]));
    send_event(mk_event(EV_RET, $urandom, $urandom, shadow_sp[0], $urandom));
    wait_results_drained();
  endtask

  task automatic test_receiver_hold();
    hold_len = 300;
    repeat (40) send_event(next_event(60));
    wait_results_drained();
  endtask

  task automatic test_random_traffic(int unsigned n, int unsigned push_pct);
    repeat (n) send_event(next_event(push_pct));
    wait_results_drained();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_traffic(300, 60);
  endtask

  initial begin : sink_proc
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 14);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual tdata %h",
                 $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[DEPTH_W-1:0] !== want.depth) begin
          $display("%0t: depth mismatch, expected %0d, actual %0d",
                   $time, want.depth, m_axis_tdata[DEPTH_W-1:0]);
          errors++;
        end
        if (m_axis_tdata[OUT_TAIL] !== want.tail) begin
          $display("%0t: tail_call mismatch, expected %b, actual %b",
                   $time, want.tail, m_axis_tdata[OUT_TAIL]);
          errors++;
        end
        if (m_axis_tdata[OUT_OVF] !== want.ovf) begin
          $display("%0t: overflow mismatch, expected %b, actual %b",
                   $time, want.ovf, m_axis_tdata[OUT_OVF]);
          errors++;
        end
        if (m_axis_tdata[OUT_UNF] !== want.unf) begin
          $display("%0t: underflow mismatch, expected %b, actual %b",
                   $time, want.unf, m_axis_tdata[OUT_UNF]);
          errors++;
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = EV_CALL;
    shadow_count  = 0;
    errors        = 0;
    hold_len      = 0;
    idle_on       = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_full_stack();
    test_receiver_hold();
    test_random_traffic(500, 55);
    test_random_traffic(500, 70);
    test_random_traffic(450, 40);
    test_back_to_back();

    repeat (80) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
